[hdl/hsv_pkg.sv]
// Package: fixed-point formats, constants and stage structs for the HSV to RGB converter.
package hsv_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int UNIT_W     = FRAC_BITS + 1;
    localparam int UNIT_ONE   = 1 << FRAC_BITS;
    localparam int CHAN_W     = 16;
    localparam int OUT_W      = 9;

    localparam int HUE_TURN   = 5760;
    localparam int HUE_SECTOR = 960;
    localparam int HUE_BIAS   = HUE_TURN - (32768 % HUE_TURN);
    localparam int HX_W       = 17;
    localparam int HY_W       = HX_W - 6;
    localparam int REM_W      = 10;
    localparam int QUO_W      = 7;

    localparam int Q15_SH     = 14;
    localparam int Q15_MUL    = (1 << Q15_SH) / 15 + 1;
    localparam int Q15_MW     = 11;
    localparam int PROD1_W    = HY_W + Q15_MW;

    localparam int D6_MUL     = 43;
    localparam int D6_SH      = 8;
    localparam int D6_MW      = 6;

    localparam int FZ_W       = REM_W + FRAC_BITS - 6;
    localparam int F_SH       = FRAC_BITS + 8;
    localparam int F_MUL      = (1 << F_SH) / 15 + 1;
    localparam int F_MW       = FRAC_BITS + 5;
    localparam int PROD2_W    = FZ_W + F_MW;

    typedef logic [UNIT_W-1:0] t_unit;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    typedef struct packed {
        logic                 valid;
        logic                 grey;
        t_sector              sector;
        t_unit                sat;
        t_unit                val;
        t_unit                p_term;
        logic [PROD2_W-1:0]   fprod;
    } t_front;

    typedef struct packed {
        logic    valid;
        logic    grey;
        t_sector sector;
        t_unit   val;
        t_unit   p_term;
        t_unit   q_term;
        t_unit   t_term;
    } t_blend;

    function automatic t_unit clamp_unit(input logic [CHAN_W-1:0] raw);
        logic [CHAN_W+1:0] wide;
        wide = {2'b00, raw};
        if (raw[CHAN_W-1]) begin
            return '0;
        end else if (wide > (CHAN_W+2)'(UNIT_ONE)) begin
            return UNIT_W'(UNIT_ONE);
        end else begin
            return UNIT_W'(raw);
        end
    endfunction

    function automatic t_unit fmul(input t_unit a, input t_unit b);
        logic [2*UNIT_W-1:0] prod;
        prod = (2*UNIT_W)'(a) * (2*UNIT_W)'(b);
        return UNIT_W'(prod >> FRAC_BITS);
    endfunction

endpackage

[hdl/hsv_front.sv]
// Front stages: input clamp, hue wrap into sector and remainder, fraction product, p term.
module hsv_front import hsv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [CHAN_W-1:0] i_hue,
    input  logic [CHAN_W-1:0] i_saturation,
    input  logic [CHAN_W-1:0] i_brightness,
    output t_front            o_front
);

    logic               r1_valid, r2_valid, r3_valid;
    logic               r1_grey, r2_grey, r3_grey;
    t_unit              r1_sat, r2_sat, r3_sat;
    t_unit              r1_val, r2_val, r3_val;
    logic [HX_W-1:0]    r1_x;
    logic [PROD1_W-1:0] r1_prod;
    logic [REM_W-1:0]   r2_rem;
    t_sector            r2_sector, r3_sector;
    t_unit              r2_p, r3_p;
    logic [PROD2_W-1:0] r3_fprod;

    t_unit              n1_sat, n1_val;
    logic [HX_W-1:0]    n1_x;
    logic [PROD1_W-1:0] n1_prod;
    logic [QUO_W-1:0]   quo;
    logic [QUO_W+D6_MW-1:0] d6_prod;
    logic [QUO_W-1:0]   d6;
    logic [HX_W-1:0]    rem_wide;
    logic [QUO_W-1:0]   sec_wide;
    logic [REM_W-1:0]   n2_rem;
    t_sector            n2_sector;
    t_unit              n2_p;
    logic [FZ_W-1:0]    fz;
    logic [PROD2_W-1:0] n3_fprod;

    // stage 1: clamp, bias hue to non-negative, hue/960 by reciprocal
    always_comb begin
        n1_sat  = clamp_unit(i_saturation);
        n1_val  = clamp_unit(i_brightness);
        n1_x    = HX_W'({~i_hue[CHAN_W-1], i_hue[CHAN_W-2:0]}) + HX_W'(HUE_BIAS);
        n1_prod = PROD1_W'(n1_x[HX_W-1:6]) * PROD1_W'(Q15_MUL);
    end

    // stage 2: remainder, sector = quotient mod 6, p term
    always_comb begin
        quo       = QUO_W'(r1_prod >> Q15_SH);
        rem_wide  = r1_x - HX_W'(quo) * HX_W'(HUE_SECTOR);
        n2_rem    = REM_W'(rem_wide);
        d6_prod   = (QUO_W+D6_MW)'(quo) * (QUO_W+D6_MW)'(D6_MUL);
        d6        = QUO_W'(d6_prod >> D6_SH);
        sec_wide  = quo - d6 * QUO_W'(6);
        n2_sector = t_sector'(sec_wide[2:0]);
        n2_p      = fmul(r1_val, t_unit'(UNIT_W'(UNIT_ONE) - r1_sat));
    end

    // stage 3: fraction numerator times reciprocal of 15
    always_comb begin
        fz       = FZ_W'(r2_rem) << (FRAC_BITS - 6);
        n3_fprod = PROD2_W'(fz) * PROD2_W'(F_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sat    <= n1_sat;
            r1_val    <= n1_val;
            r1_grey   <= (n1_sat == '0);
            r1_x      <= n1_x;
            r1_prod   <= n1_prod;
            r2_sat    <= r1_sat;
            r2_val    <= r1_val;
            r2_grey   <= r1_grey;
            r2_rem    <= n2_rem;
            r2_sector <= n2_sector;
            r2_p      <= n2_p;
            r3_sat    <= r2_sat;
            r3_val    <= r2_val;
            r3_grey   <= r2_grey;
            r3_sector <= r2_sector;
            r3_p      <= r2_p;
            r3_fprod  <= n3_fprod;
        end
    end

    always_comb begin
        o_front.valid  = r3_valid;
        o_front.grey   = r3_grey;
        o_front.sector = r3_sector;
        o_front.sat    = r3_sat;
        o_front.val    = r3_val;
        o_front.p_term = r3_p;
        o_front.fprod  = r3_fprod;
    end

endmodule

[hdl/hsv_blend.sv]
// Blend stages: s*f and s*(1-f) products, then q and t terms.
module hsv_blend import hsv_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_front i_front,
    output t_blend o_blend
);

    logic    r4_valid, r5_valid;
    logic    r4_grey, r5_grey;
    t_sector r4_sector, r5_sector;
    t_unit   r4_val, r5_val;
    t_unit   r4_p, r5_p;
    t_unit   r4_sf, r4_s1f;
    t_unit   r5_q, r5_t;

    t_unit   frac;
    t_unit   n4_sf, n4_s1f;
    t_unit   n5_q, n5_t;

    always_comb begin
        frac   = UNIT_W'(i_front.fprod >> F_SH);
        n4_sf  = fmul(i_front.sat, frac);
        n4_s1f = fmul(i_front.sat, t_unit'(UNIT_W'(UNIT_ONE) - frac));
    end

    always_comb begin
        n5_q = fmul(r4_val, t_unit'(UNIT_W'(UNIT_ONE) - r4_sf));
        n5_t = fmul(r4_val, t_unit'(UNIT_W'(UNIT_ONE) - r4_s1f));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= i_front.valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_grey   <= i_front.grey;
            r4_sector <= i_front.sector;
            r4_val    <= i_front.val;
            r4_p      <= i_front.p_term;
            r4_sf     <= n4_sf;
            r4_s1f    <= n4_s1f;
            r5_grey   <= r4_grey;
            r5_sector <= r4_sector;
            r5_val    <= r4_val;
            r5_p      <= r4_p;
            r5_q      <= n5_q;
            r5_t      <= n5_t;
        end
    end

    always_comb begin
        o_blend.valid  = r5_valid;
        o_blend.grey   = r5_grey;
        o_blend.sector = r5_sector;
        o_blend.val    = r5_val;
        o_blend.p_term = r5_p;
        o_blend.q_term = r5_q;
        o_blend.t_term = r5_t;
    end

endmodule

[hdl/hsv_to_rgb_converter_unit.sv]
// Top level: HSV to RGB converter, six-stage pipeline with sector select at the output.
// An accepted input transfer passes the front, blend and output stage registers in turn.
// Throughput: one transfer per cycle; every stage holds while the output is stalled.
// The rate is set by the stage pipeline; the multipliers sit in the front and blend stages.
// Reset (synchronous, active low) clears the stage valid bits only.
module hsv_to_rgb_converter_unit import hsv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CHAN_W-1:0] i_hue,
    input  logic [CHAN_W-1:0] i_saturation,
    input  logic [CHAN_W-1:0] i_brightness,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [OUT_W-1:0]  o_red,
    output logic [OUT_W-1:0]  o_green,
    output logic [OUT_W-1:0]  o_blue
);

    logic   en;
    t_front front;
    t_blend blend;

    logic   r6_valid;
    t_unit  r6_red, r6_green, r6_blue;
    t_unit  n6_red, n6_green, n6_blue;

    assign en      = !(r6_valid && i_stall);
    assign o_stall = !en;

    hsv_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_valid),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_front      (front)
    );

    hsv_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_front (front),
        .o_blend (blend)
    );

    always_comb begin
        if (blend.grey) begin
            n6_red   = blend.val;
            n6_green = blend.val;
            n6_blue  = blend.val;
        end else begin
            unique case (blend.sector)
                SEC_RED_YEL: begin
                    n6_red   = blend.val;
                    n6_green = blend.t_term;
                    n6_blue  = blend.p_term;
                end
                SEC_YEL_GRN: begin
                    n6_red   = blend.q_term;
                    n6_green = blend.val;
                    n6_blue  = blend.p_term;
                end
                SEC_GRN_CYN: begin
                    n6_red   = blend.p_term;
                    n6_green = blend.val;
                    n6_blue  = blend.t_term;
                end
                SEC_CYN_BLU: begin
                    n6_red   = blend.p_term;
                    n6_green = blend.q_term;
                    n6_blue  = blend.val;
                end
                SEC_BLU_MAG: begin
                    n6_red   = blend.t_term;
                    n6_green = blend.p_term;
                    n6_blue  = blend.val;
                end
                default: begin
                    n6_red   = blend.val;
                    n6_green = blend.p_term;
                    n6_blue  = blend.q_term;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (en) begin
            r6_valid <= blend.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_red   <= n6_red;
            r6_green <= n6_green;
            r6_blue  <= n6_blue;
        end
    end

    assign o_valid = r6_valid;
    assign o_red   = OUT_W'(r6_red);
    assign o_green = OUT_W'(r6_green);
    assign o_blue  = OUT_W'(r6_blue);

endmodule

[tb/hsv_checker.sv]
// Checker for the HSV to RGB converter: predicts each color from input transfers, compares outputs.
module hsv_checker import hsv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [CHAN_W-1:0] i_hue,
    input  logic [CHAN_W-1:0] i_saturation,
    input  logic [CHAN_W-1:0] i_brightness,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [OUT_W-1:0]  i_red,
    input  logic [OUT_W-1:0]  i_green,
    input  logic [OUT_W-1:0]  i_blue,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_unit red;
        t_unit green;
        t_unit blue;
    } t_rgb;

    t_rgb rgb_expected[$];
    t_rgb want;
    int   mismatches = 0;

    function automatic int unit_level(input logic [CHAN_W-1:0] raw);
        int x;
        x = $signed(raw);
        if (x < 0) return 0;
        if (x > UNIT_ONE) return UNIT_ONE;
        return x;
    endfunction

    function automatic int scale(input int a, input int b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    function automatic t_rgb hsv_to_rgb(input logic [CHAN_W-1:0] hue,
                                        input logic [CHAN_W-1:0] sat_raw,
                                        input logic [CHAN_W-1:0] val_raw);
        int      h, s, v, f, p, q, t, r, g, b;
        t_sector sec;
        t_rgb    c;
        s = unit_level(sat_raw);
        v = unit_level(val_raw);
        h = $signed(hue) % HUE_TURN;
        if (h < 0) h += HUE_TURN;
        if (s == 0) begin
            r = v;
            g = v;
            b = v;
        end else begin
            sec = t_sector'(h / HUE_SECTOR);
            f   = ((h % HUE_SECTOR) << FRAC_BITS) / HUE_SECTOR;
            p   = scale(v, UNIT_ONE - s);
            q   = scale(v, UNIT_ONE - scale(s, f));
            t   = scale(v, UNIT_ONE - scale(s, UNIT_ONE - f));
            case (sec)
                SEC_RED_YEL: begin r = v; g = t; b = p; end
                SEC_YEL_GRN: begin r = q; g = v; b = p; end
                SEC_GRN_CYN: begin r = p; g = v; b = t; end
                SEC_CYN_BLU: begin r = p; g = q; b = v; end
                SEC_BLU_MAG: begin r = t; g = p; b = v; end
                default:     begin r = v; g = p; b = q; end
            endcase
        end
        c.red   = UNIT_W'(r);
        c.green = UNIT_W'(g);
        c.blue  = UNIT_W'(b);
        return c;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                rgb_expected.push_back(hsv_to_rgb(i_hue, i_saturation, i_brightness));
            end
            if (i_out_valid && !i_out_stall) begin
                if (rgb_expected.size() == 0) begin
                    $error("unexpected output transfer: red %0d green %0d blue %0d",
                           i_red, i_green, i_blue);
                    mismatches++;
                end else begin
                    want = rgb_expected.pop_front();
                    if (i_red !== want.red) begin
                        $error("red: expected %0d, actual %0d", want.red, i_red);
                        mismatches++;
                    end
                    if (i_green !== want.green) begin
                        $error("green: expected %0d, actual %0d", want.green, i_green);
                        mismatches++;
                    end
                    if (i_blue !== want.blue) begin
                        $error("blue: expected %0d, actual %0d", want.blue, i_blue);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= rgb_expected.size();
    end

endmodule

[tb/tb.sv]
// Testbench top: drives HSV colors into the converter, stalls its output and reports the verdict.
module tb import hsv_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_COLORS = 1250;
    localparam int QUIET_TAIL    = 150;
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 40;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              o_stall;
    logic [CHAN_W-1:0] i_hue        = '0;
    logic [CHAN_W-1:0] i_saturation = '0;
    logic [CHAN_W-1:0] i_brightness = '0;
    logic              o_valid;
    logic              i_stall      = 1'b0;
    logic [OUT_W-1:0]  o_red;
    logic [OUT_W-1:0]  o_green;
    logic [OUT_W-1:0]  o_blue;

    int fail_count;
    int pending;
    int colors_sent = 0;
    bit quiet       = 1'b0;
    bit hold_done   = 1'b0;

    hsv_to_rgb_converter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_hue       (i_hue),
        .i_saturation(i_saturation),
        .i_brightness(i_brightness),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue)
    );

    hsv_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_hue       (i_hue),
        .i_saturation(i_saturation),
        .i_brightness(i_brightness),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_red       (o_red),
        .i_green     (o_green),
        .i_blue      (o_blue),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic send_color(input int h, input int s, input int v);
        int gap;
        i_valid      <= 1'b1;
        i_hue        <= CHAN_W'(h);
        i_saturation <= CHAN_W'(s);
        i_brightness <= CHAN_W'(v);
        do @(posedge i_clk); while (o_stall);
        colors_sent++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic int pick_hue();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom();
            2:       return $urandom_range(0, 5) * HUE_SECTOR + $urandom_range(0, 1) - 1;
            default: return $urandom_range(0, HUE_TURN - 1);
        endcase
    endfunction

    function automatic int pick_level();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2:       return 0;
            3:       return UNIT_ONE;
            4:       return $urandom_range(UNIT_ONE - 2, UNIT_ONE + 2);
            default: return $urandom_range(0, UNIT_ONE);
        endcase
    endfunction

    initial begin : rx_side
        int n;
        forever begin
            @(posedge i_clk);
            if (!hold_done && colors_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 4);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : tx_side
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // hue wrap, sector edges, clamping and grey
        send_color(-32768, 256, 256);
        send_color(32767, 256, 256);
        send_color(0, 256, 256);
        send_color(-1, 256, 256);
        send_color(5759, 256, 256);
        send_color(5760, 256, 256);
        send_color(-5760, 256, 256);
        send_color(959, 256, 256);
        send_color(960, 256, 256);
        send_color(1920, 200, 180);
        send_color(2880, 200, 180);
        send_color(3840, 200, 180);
        send_color(4800, 200, 180);
        send_color(5000, 1, 256);
        send_color(700, 255, 256);
        send_color(1500, 257, 100);
        send_color(2500, 32767, 32767);
        send_color(3000, -32768, 200);
        send_color(4000, 0, 77);
        send_color(4500, -1, 256);
        send_color(300, 128, -32768);
        send_color(3300, 128, 0);
        send_color(5500, 128, 257);
        send_color(1234, 128, 1);
        i_valid <= 1'b0;
        wait_drained();

        for (int k = 0; k < RANDOM_COLORS; k++) begin
            if (k == RANDOM_COLORS - QUIET_TAIL) quiet = 1'b1;
            send_color(pick_hue(), pick_level(), pick_level());
        end
        i_valid <= 1'b0;

        wait_drained();
        repeat (12) @(posedge i_clk);
        $display("Converted %0d colors: edge cases of hue, saturation and value, then random",
                 colors_sent);
        $display("colors with idle bursts on both sides, a long output hold and a mid-run drain.");
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
